// ===== hw/rtl/spbt_pkg.sv =====
`timescale 1ns / 1ps

package spbt_pkg;

    localparam int SLOT_COUNT = 4;

    // input item kinds
    localparam logic [1:0] KIND_POLL   = 2'd0;
    localparam logic [1:0] KIND_STATUS = 2'd1;
    localparam logic [1:0] KIND_RESET  = 2'd2;

    // register indexes (paddr[4:2])
    localparam logic [2:0] REG_INTERVAL = 3'd0;
    localparam logic [2:0] REG_CAP      = 3'd1;
    localparam logic [2:0] REG_GRACE    = 3'd2;
    localparam logic [2:0] REG_ENABLE   = 3'd3;
    localparam logic [2:0] REG_ACTIVE   = 3'd4;

    localparam logic [23:0] INTERVAL_RST = 24'd30000;
    localparam logic [23:0] CAP_RST      = 24'd60000;
    localparam logic [7:0]  GRACE_RST    = 8'd2;

    // divide by three: floor(x * RECIP3 / 2^RECIP_SHIFT) is exact for x < 2^17
    localparam logic [15:0] RECIP3      = 16'd43691;
    localparam int          RECIP_SHIFT = 17;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROD,
        S_APPLY,
        S_SUM,
        S_SCALE,
        S_OUT
    } state_t;

    typedef struct packed {
        logic load_in;
        logic calc;
        logic apply;
        logic sum;
        logic scale;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_sts_t;

endpackage

// ===== hw/rtl/sensor_poll_backoff_tracker_core.sv =====
`timescale 1ns / 1ps
// A result beat is offered once the controller has walked its input beat through
// fetch, back-off product, slot update, slot sum, divide and output load; output
// load waits only while the receiver still stalls the previous result beat.
// The controller takes one item at a time: no new item is accepted until output load.
// Output register lets the next item be accepted while a result waits.
// Reset (rst_n, async, active low) clears all slot state and restores config.

module sensor_poll_backoff_tracker_core
    import spbt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // config port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // input channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            kind,
    input  logic [1:0]            slot,
    input  logic                  fetch_ok,
    input  logic signed [15:0]    temperature_in,
    input  logic signed [15:0]    humidity_in,
    input  logic [31:0]           now_ms,
    // result channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [SLOT_COUNT-1:0] due_mask,
    output logic [SLOT_COUNT-1:0] valid_mask,
    output logic [7:0]            slot_failures,
    output logic [23:0]           retry_delay_ms,
    output logic                  average_ok,
    output logic signed [15:0]    average_temperature,
    output logic [9:0]            average_humidity
);

    dp_cmd_t cmd;
    dp_sts_t sts;
    logic    cfg_we;

    // zero-wait port: write lands on the access cycle
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    spbt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: config regs, slot state, back-off math, averaging, output beat
    spbt_dp u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_we              (cfg_we),
        .cfg_idx             (paddr[4:2]),
        .cfg_wdata           (pwdata),
        .cfg_rdata           (prdata),
        .kind                (kind),
        .slot                (slot),
        .fetch_ok            (fetch_ok),
        .temperature_in      (temperature_in),
        .humidity_in         (humidity_in),
        .now_ms              (now_ms),
        .out_stall           (out_stall),
        .out_valid           (out_valid),
        .due_mask            (due_mask),
        .valid_mask          (valid_mask),
        .slot_failures       (slot_failures),
        .retry_delay_ms      (retry_delay_ms),
        .average_ok          (average_ok),
        .average_temperature (average_temperature),
        .average_humidity    (average_humidity),
        .cmd                 (cmd),
        .sts                 (sts)
    );

endmodule

// ===== hw/rtl/spbt_ctrl.sv =====
`timescale 1ns / 1ps

module spbt_ctrl
    import spbt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_PROD;
                end
            end
            S_PROD:  state_next = S_APPLY;
            S_APPLY: state_next = S_SUM;
            S_SUM:   state_next = S_SCALE;
            S_SCALE: state_next = S_OUT;
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.load_in = in_valid;
            end
            S_PROD:  cmd.calc  = 1'b1;
            S_APPLY: cmd.apply = 1'b1;
            S_SUM:   cmd.sum   = 1'b1;
            S_SCALE: cmd.scale = 1'b1;
            S_OUT:   cmd.load_out = sts.out_free;
            default: in_stall = 1'b1;
        endcase
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_PROD))
        else $error("accepted beat did not start processing");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> sts.out_free)
        else $error("result loaded over an untaken beat");

    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("input open while busy");

    a_apply_then_sum: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.apply |=> cmd.sum)
        else $error("sum did not follow slot update");

endmodule

// ===== hw/rtl/spbt_dp.sv =====
`timescale 1ns / 1ps

module spbt_dp
    import spbt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_idx,
    input  logic [31:0]           cfg_wdata,
    output logic [31:0]           cfg_rdata,
    input  logic [1:0]            kind,
    input  logic [1:0]            slot,
    input  logic                  fetch_ok,
    input  logic signed [15:0]    temperature_in,
    input  logic signed [15:0]    humidity_in,
    input  logic [31:0]           now_ms,
    input  logic                  out_stall,
    output logic                  out_valid,
    output logic [SLOT_COUNT-1:0] due_mask,
    output logic [SLOT_COUNT-1:0] valid_mask,
    output logic [7:0]            slot_failures,
    output logic [23:0]           retry_delay_ms,
    output logic                  average_ok,
    output logic signed [15:0]    average_temperature,
    output logic [9:0]            average_humidity,
    input  dp_cmd_t               cmd,
    output dp_sts_t               sts
);

    // config
    logic [23:0]           interval_reg;
    logic [23:0]           cap_reg;
    logic [7:0]            grace_reg;
    logic [SLOT_COUNT-1:0] en_reg;
    logic [SLOT_COUNT-1:0] act_reg;

    // per-slot state
    logic [31:0]        npt_reg  [SLOT_COUNT];
    logic [7:0]         fail_reg [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] vld_reg;
    logic signed [15:0] st_t_reg [SLOT_COUNT];
    logic [9:0]         st_h_reg [SLOT_COUNT];

    // captured beat
    logic [1:0]         kind_reg;
    logic [1:0]         slot_reg;
    logic               ok_reg;
    logic signed [15:0] t_reg;
    logic signed [15:0] h_reg;
    logic [31:0]        now_reg;

    // work registers
    logic        plaus_reg;
    logic [7:0]  fail_new_reg;
    logic [31:0] prod_reg;
    logic [23:0] delay_reg;
    logic [SLOT_COUNT-1:0] due_reg;
    logic [SLOT_COUNT-1:0] vmask_reg;
    logic [7:0]  sfail_reg;
    logic [2:0]  cnt_reg;
    logic        neg_t_reg;
    logic [17:0] abs_t_reg;
    logic [11:0] sum_h_reg;
    logic [17:0] qt_reg;
    logic [11:0] qh_reg;

    // output register
    logic                  out_valid_reg;
    logic [SLOT_COUNT-1:0] due_out_reg;
    logic [SLOT_COUNT-1:0] vld_out_reg;
    logic [7:0]            sfail_out_reg;
    logic [23:0]           delay_out_reg;
    logic                  avg_ok_reg;
    logic signed [15:0]    avg_t_reg;
    logic [9:0]            avg_h_reg;

    logic                  slot_ok;
    logic                  poll_hit;
    logic [7:0]            fail_cur;
    logic [7:0]            fail_inc;
    logic                  plaus;
    logic [23:0]           fail_delay;
    logic [SLOT_COUNT-1:0] en_new;
    logic [SLOT_COUNT-1:0] due_c;
    logic signed [17:0]    sum_t_c;
    logic [11:0]           sum_h_c;
    logic [2:0]            cnt_c;
    logic [33:0]           q3_t;
    logic [27:0]           q3_h;
    logic [17:0]           qt_c;
    logic [11:0]           qh_c;
    logic [17:0]           avg_t_full;

    assign slot_ok  = ({1'b0, slot_reg} < 3'(SLOT_COUNT));
    assign poll_hit = slot_ok && (kind_reg == KIND_POLL) && en_reg[slot_reg];
    assign fail_cur = fail_reg[slot_reg];
    assign fail_inc = (fail_cur == 8'hFF) ? fail_cur : fail_cur + 8'd1;
    assign plaus    = ok_reg && (t_reg > -16'sd1000) && (h_reg > 16'sd0)
                      && (h_reg <= 16'sd1000);
    assign fail_delay = (prod_reg < {8'd0, cap_reg}) ? prod_reg[23:0] : cap_reg;
    assign en_new   = cfg_wdata[SLOT_COUNT-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            kind_reg <= kind;
            slot_reg <= slot;
            ok_reg   <= fetch_ok;
            t_reg    <= temperature_in;
            h_reg    <= humidity_in;
            now_reg  <= now_ms;
        end
        if (cmd.calc)
        begin
            plaus_reg    <= plaus;
            fail_new_reg <= fail_inc;
            prod_reg     <= 32'(interval_reg) * 32'(fail_inc);
        end
    end

    // config registers and slot state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= INTERVAL_RST;
            cap_reg      <= CAP_RST;
            grace_reg    <= GRACE_RST;
            en_reg       <= '0;
            act_reg      <= '1;
            vld_reg      <= '0;
            delay_reg    <= '0;
            for (int s = 0; s < SLOT_COUNT; s++)
            begin
                npt_reg[s]  <= '0;
                fail_reg[s] <= '0;
                st_t_reg[s] <= '0;
                st_h_reg[s] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    REG_INTERVAL: interval_reg <= cfg_wdata[23:0];
                    REG_CAP:      cap_reg      <= cfg_wdata[23:0];
                    REG_GRACE:    grace_reg    <= cfg_wdata[7:0];
                    REG_ENABLE:
                    begin
                        for (int s = 0; s < SLOT_COUNT; s++)
                        begin
                            if (en_reg[s] && !en_new[s])
                            begin
                                vld_reg[s]  <= 1'b0;
                                fail_reg[s] <= '0;
                            end
                            else if (!en_reg[s] && en_new[s])
                            begin
                                npt_reg[s] <= '0;
                            end
                        end
                        en_reg <= en_new;
                    end
                    REG_ACTIVE:   act_reg <= cfg_wdata[SLOT_COUNT-1:0];
                    default:      ;
                endcase
            end
            if (cmd.apply)
            begin
                delay_reg <= '0;
                if (poll_hit)
                begin
                    if (plaus_reg)
                    begin
                        st_t_reg[slot_reg] <= t_reg;
                        st_h_reg[slot_reg] <= h_reg[9:0];
                        vld_reg[slot_reg]  <= 1'b1;
                        fail_reg[slot_reg] <= '0;
                        delay_reg          <= interval_reg;
                        npt_reg[slot_reg]  <= now_reg + {8'd0, interval_reg};
                    end
                    else
                    begin
                        fail_reg[slot_reg] <= fail_new_reg;
                        if (fail_new_reg > grace_reg)
                        begin
                            vld_reg[slot_reg] <= 1'b0;
                        end
                        delay_reg         <= fail_delay;
                        npt_reg[slot_reg] <= now_reg + {8'd0, fail_delay};
                    end
                end
                else if (slot_ok && (kind_reg == KIND_RESET))
                begin
                    npt_reg[slot_reg]  <= '0;
                    fail_reg[slot_reg] <= '0;
                    vld_reg[slot_reg]  <= 1'b0;
                    st_t_reg[slot_reg] <= '0;
                    st_h_reg[slot_reg] <= '0;
                end
            end
        end
    end

    always_comb
    begin
        sum_t_c = '0;
        sum_h_c = '0;
        cnt_c   = '0;
        for (int s = 0; s < SLOT_COUNT; s++)
        begin
            due_c[s] = en_reg[s] && (now_reg >= npt_reg[s]);
            if (en_reg[s] && act_reg[s] && vld_reg[s])
            begin
                sum_t_c = sum_t_c + {{2{st_t_reg[s][15]}}, st_t_reg[s]};
                sum_h_c = sum_h_c + {2'd0, st_h_reg[s]};
                cnt_c   = cnt_c + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sum)
        begin
            due_reg   <= due_c;
            vmask_reg <= vld_reg;
            sfail_reg <= slot_ok ? fail_reg[slot_reg] : 8'd0;
            cnt_reg   <= cnt_c;
            neg_t_reg <= sum_t_c[17];
            abs_t_reg <= sum_t_c[17] ? 18'(-sum_t_c) : 18'(sum_t_c);
            sum_h_reg <= sum_h_c;
        end
        if (cmd.scale)
        begin
            qt_reg <= qt_c;
            qh_reg <= qh_c;
        end
    end

    // divide by contributing count
    assign q3_t = 34'(abs_t_reg) * 34'(RECIP3);
    assign q3_h = 28'(sum_h_reg) * 28'(RECIP3);

    always_comb
    begin
        case (cnt_reg)
            3'd2:
            begin
                qt_c = abs_t_reg >> 1;
                qh_c = sum_h_reg >> 1;
            end
            3'd3:
            begin
                qt_c = 18'(q3_t >> RECIP_SHIFT);
                qh_c = 12'(q3_h >> RECIP_SHIFT);
            end
            3'd4:
            begin
                qt_c = abs_t_reg >> 2;
                qh_c = sum_h_reg >> 2;
            end
            default:
            begin
                qt_c = abs_t_reg;
                qh_c = sum_h_reg;
            end
        endcase
    end

    assign avg_t_full = neg_t_reg ? 18'(-qt_reg) : qt_reg;
    assign sts.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            due_out_reg   <= due_reg;
            vld_out_reg   <= vmask_reg;
            sfail_out_reg <= sfail_reg;
            delay_out_reg <= delay_reg;
            avg_ok_reg    <= (cnt_reg != 3'd0);
            avg_t_reg     <= (cnt_reg != 3'd0) ? avg_t_full[15:0] : 16'sd0;
            avg_h_reg     <= (cnt_reg != 3'd0) ? qh_reg[9:0] : 10'd0;
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_INTERVAL: cfg_rdata = {8'd0, interval_reg};
            REG_CAP:      cfg_rdata = {8'd0, cap_reg};
            REG_GRACE:    cfg_rdata = {24'd0, grace_reg};
            REG_ENABLE:   cfg_rdata = 32'(en_reg);
            REG_ACTIVE:   cfg_rdata = 32'(act_reg);
            default:      cfg_rdata = '0;
        endcase
    end

    assign out_valid           = out_valid_reg;
    assign due_mask            = due_out_reg;
    assign valid_mask          = vld_out_reg;
    assign slot_failures       = sfail_out_reg;
    assign retry_delay_ms      = delay_out_reg;
    assign average_ok          = avg_ok_reg;
    assign average_temperature = avg_t_reg;
    assign average_humidity    = avg_h_reg;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scale |-> (cnt_reg <= 3'(SLOT_COUNT)))
        else $error("contributor count out of range");

    a_fail_clears_on_good: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.apply && poll_hit && plaus_reg) |=> (fail_reg[slot_reg] == 8'd0))
        else $error("good poll left failures set");

    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(delay_out_reg)))
        else $error("stalled result beat changed");

endmodule

// ===== bench/spbt_checker.sv =====
`timescale 1ns / 1ps

module spbt_checker
    import spbt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    input  logic                  pready,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [1:0]            kind,
    input  logic [1:0]            slot,
    input  logic                  fetch_ok,
    input  logic signed [15:0]    temperature_in,
    input  logic signed [15:0]    humidity_in,
    input  logic [31:0]           now_ms,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [SLOT_COUNT-1:0] due_mask,
    input  logic [SLOT_COUNT-1:0] valid_mask,
    input  logic [7:0]            slot_failures,
    input  logic [23:0]           retry_delay_ms,
    input  logic                  average_ok,
    input  logic signed [15:0]    average_temperature,
    input  logic [9:0]            average_humidity,
    output int                    fail_count,
    output int                    results_seen,
    output int                    outstanding
);

    typedef struct packed {
        logic [SLOT_COUNT-1:0] due;
        logic [SLOT_COUNT-1:0] valid;
        logic [7:0]            fails;
        logic [23:0]           delay;
        logic                  avg_ok;
        logic signed [15:0]    avg_t;
        logic [9:0]            avg_h;
    } slot_status_t;

    // shadow registers
    logic [23:0]           interval_ms;
    logic [23:0]           cap_ms;
    logic [7:0]            grace;
    logic [SLOT_COUNT-1:0] en_mask;
    logic [SLOT_COUNT-1:0] act_mask;

    // shadow slot table
    logic [31:0]        next_poll    [SLOT_COUNT];
    logic [7:0]         fail_cnt     [SLOT_COUNT];
    logic               have_reading [SLOT_COUNT];
    logic signed [15:0] temp_st      [SLOT_COUNT];
    logic signed [15:0] hum_st       [SLOT_COUNT];

    slot_status_t pending_status [$];

    function automatic void clear_slot(int s);
        next_poll[s]    = '0;
        fail_cnt[s]     = '0;
        have_reading[s] = 1'b0;
        temp_st[s]      = '0;
        hum_st[s]       = '0;
    endfunction

    function automatic void reset_tracker();
        interval_ms = INTERVAL_RST;
        cap_ms      = CAP_RST;
        grace       = GRACE_RST;
        en_mask     = '0;
        act_mask    = '1;
        for (int s = 0; s < SLOT_COUNT; s++)
            clear_slot(s);
    endfunction

    function automatic void write_register(logic [2:0] idx, logic [31:0] v);
        logic [SLOT_COUNT-1:0] nm;
        nm = v[SLOT_COUNT-1:0];
        case (idx)
            REG_INTERVAL: interval_ms = v[23:0];
            REG_CAP:      cap_ms = v[23:0];
            REG_GRACE:    grace = v[7:0];
            REG_ENABLE:
            begin
                // falling enable drops reading and failures, rising makes it due
                for (int s = 0; s < SLOT_COUNT; s++)
                begin
                    if (en_mask[s] && !nm[s])
                    begin
                        have_reading[s] = 1'b0;
                        fail_cnt[s]     = '0;
                    end
                    else if (!en_mask[s] && nm[s])
                    begin
                        next_poll[s] = '0;
                    end
                end
                en_mask = nm;
            end
            REG_ACTIVE:   act_mask = nm;
            default:      ;
        endcase
    endfunction

    function automatic slot_status_t apply_poll_item(logic [1:0] k, logic [1:0] sl, logic ok,
                                                     logic signed [15:0] t, logic signed [15:0] h,
                                                     logic [31:0] now);
        slot_status_t r;
        logic [63:0]  prod;
        logic [31:0]  delay;
        int           ti, hi, sum_t, sum_h, n;
        ti    = int'(t);
        hi    = int'(h);
        delay = '0;
        sum_t = 0;
        sum_h = 0;
        n     = 0;
        r     = '0;
        if (sl < SLOT_COUNT && k == KIND_POLL && en_mask[sl])
        begin
            if (ok && ti > -1000 && hi > 0 && hi <= 1000)
            begin
                temp_st[sl]      = t;
                hum_st[sl]       = h;
                have_reading[sl] = 1'b1;
                fail_cnt[sl]     = '0;
                delay            = 32'(interval_ms);
            end
            else
            begin
                if (fail_cnt[sl] != 8'hFF)
                    fail_cnt[sl] = fail_cnt[sl] + 8'd1;
                if (fail_cnt[sl] > grace)
                    have_reading[sl] = 1'b0;
                prod  = 64'(interval_ms) * 64'(fail_cnt[sl]);
                delay = (prod < 64'(cap_ms)) ? prod[31:0] : 32'(cap_ms);
            end
            next_poll[sl] = now + delay;
        end
        else if (sl < SLOT_COUNT && k == KIND_RESET)
        begin
            clear_slot(int'(sl));
        end

        for (int s = 0; s < SLOT_COUNT; s++)
        begin
            r.due[s]   = en_mask[s] && now >= next_poll[s];
            r.valid[s] = have_reading[s];
            if (en_mask[s] && act_mask[s] && have_reading[s])
            begin
                sum_t += int'(temp_st[s]);
                sum_h += int'(hum_st[s]);
                n++;
            end
        end
        r.fails = (sl < SLOT_COUNT) ? fail_cnt[sl] : 8'd0;
        r.delay = delay[23:0];
        if (n > 0)
        begin
            r.avg_ok = 1'b1;
            r.avg_t  = 16'(sum_t / n);
            r.avg_h  = 10'(sum_h / n);
        end
        return r;
    endfunction

    function automatic int field_bad(string name, logic [31:0] want, logic [31:0] got);
        if (want === got)
            return 0;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        slot_status_t got;
        slot_status_t want;
        int           errs;
        if (!rst_n)
        begin
            reset_tracker();
            pending_status.delete();
            fail_count   <= 0;
            results_seen <= 0;
            outstanding  <= 0;
        end
        else
        begin
            errs = 0;
            if (psel && penable && pwrite && pready)
                write_register(paddr[4:2], pwdata);

            // retire before accepting: a result never belongs to this edge's input
            if (out_valid && !out_stall)
            begin
                got = '{due_mask, valid_mask, slot_failures, retry_delay_ms,
                        average_ok, average_temperature, average_humidity};
                if (pending_status.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, got %0h", $time, got);
                    errs++;
                end
                else
                begin
                    want = pending_status.pop_front();
                    errs += field_bad("due_mask", want.due, got.due);
                    errs += field_bad("valid_mask", want.valid, got.valid);
                    errs += field_bad("slot_failures", want.fails, got.fails);
                    errs += field_bad("retry_delay_ms", want.delay, got.delay);
                    errs += field_bad("average_ok", want.avg_ok, got.avg_ok);
                    errs += field_bad("average_temperature", want.avg_t, got.avg_t);
                    errs += field_bad("average_humidity", want.avg_h, got.avg_h);
                end
                results_seen <= results_seen + 1;
            end

            if (in_valid && !in_stall)
                pending_status.push_back(apply_poll_item(kind, slot, fetch_ok, temperature_in,
                                                         humidity_in, now_ms));

            fail_count  <= fail_count + errs;
            outstanding <= pending_status.size();
        end
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the sensor slot tracker. The checker instance
// mirrors every register write and input beat, predicts the status beat and
// compares it; this module only drives the ports and decides pass or fail.
module tb
    import spbt_pkg::*;
();

    localparam logic [1:0] KIND_UNUSED   = 2'd3;
    localparam int         RANDOM_PHASES = 8;
    localparam int         PHASE_ITEMS   = 95;
    localparam int         SAT_RUN       = 270;   // enough failures to pin the counter at 255
    localparam int         LONG_HOLD     = 300;   // receiver hold-off, in cycles
    localparam int         QUIET_LIMIT   = 4000;  // cycles with no beat and no bus access

    logic                  clk            = 1'b0;
    logic                  rst_n          = 1'b0;
    logic                  psel           = 1'b0;
    logic                  penable        = 1'b0;
    logic                  pwrite         = 1'b0;
    logic [4:0]            paddr          = '0;
    logic [31:0]           pwdata         = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  in_valid       = 1'b0;
    logic                  in_stall;
    logic [1:0]            kind           = KIND_STATUS;
    logic [1:0]            slot           = '0;
    logic                  fetch_ok       = 1'b0;
    logic signed [15:0]    temperature_in = '0;
    logic signed [15:0]    humidity_in    = '0;
    logic [31:0]           now_ms         = '0;
    logic                  out_valid;
    logic                  out_stall      = 1'b0;
    logic [SLOT_COUNT-1:0] due_mask;
    logic [SLOT_COUNT-1:0] valid_mask;
    logic [7:0]            slot_failures;
    logic [23:0]           retry_delay_ms;
    logic                  average_ok;
    logic signed [15:0]    average_temperature;
    logic [9:0]            average_humidity;

    int fail_count;
    int results_seen;
    int outstanding;

    // stimulus state; rx_gaps and hold_request are shared with the receiver process
    bit                    tx_gaps       = 1'b1;
    bit                    rx_gaps       = 1'b1;
    bit                    hold_request  = 1'b0;
    logic [31:0]           sim_now       = '0;
    logic [SLOT_COUNT-1:0] cur_enable    = '0;
    int                    items_sent    = 0;
    int                    reg_writes    = 0;
    int                    quiet_cycles  = 0;

    wire in_fire  = in_valid && !in_stall;
    wire out_fire = out_valid && !out_stall;

    sensor_poll_backoff_tracker_core dut (.*);

    spbt_checker chk (.*);

    always #5 clk = ~clk;

    // Watchdog: any beat or bus access restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || in_fire || out_fire || psel)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT)
            begin
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    // Receiver: random stall bursts, or one long hold-off on
    // request so the block backs up and stalls its input.
    initial
    begin : receiver
        int n;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall    <= 1'b0;
                hold_request = 1'b0;
            end
            else if (rx_gaps && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 6);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // One input beat. Valid stays high after acceptance unless a gap follows,
    // so back-to-back beats never lower and raise valid in the same step.
    task automatic send_item(logic [1:0] k, logic [1:0] sl, logic ok,
                             logic [15:0] t, logic [15:0] h, logic [31:0] now);
        in_valid       <= 1'b1;
        kind           <= k;
        slot           <= sl;
        fetch_ok       <= ok;
        temperature_in <= t;
        humidity_in    <= h;
        now_ms         <= now;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
        if (tx_gaps && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Sender pause: nothing offered until every status beat is back.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Setup cycle, access cycle, then the bus goes idle.
    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        reg_writes++;
    endtask

    task automatic set_config(logic [31:0] iv, logic [31:0] cv, logic [31:0] gv,
                              logic [31:0] ev, logic [31:0] av);
        write_reg(REG_INTERVAL, iv);
        write_reg(REG_CAP, cv);
        write_reg(REG_GRACE, gv);
        write_reg(REG_ENABLE, ev);
        write_reg(REG_ACTIVE, av);
        cur_enable = ev[SLOT_COUNT-1:0];
    endtask

    // Mostly well-formed polls on enabled slots against a clock that moves
    // forward; the rest is failures, queries, resets and raw noise.
    task automatic send_random_item();
        int          pick;
        int          neg;
        logic [1:0]  k;
        logic [1:0]  sl;
        logic        ok;
        logic [15:0] t;
        logic [15:0] h;
        logic [31:0] now;
        pick = $urandom_range(0, 99);
        k    = KIND_POLL;
        ok   = 1'b1;
        sl   = 2'($urandom_range(0, 3));
        t    = 16'($urandom_range(0, 1998)) - 16'd999;
        h    = 16'($urandom_range(1, 1000));
        if (pick < 75 && cur_enable != '0)
            while (!cur_enable[sl]) sl = 2'($urandom_range(0, 3));

        if (pick >= 55 && pick < 75)
        begin
            // failed poll: no fetch, or a reading outside the plausible window
            case ($urandom_range(0, 3))
                0: ok = 1'b0;
                1: t = 16'(-1000 - int'($urandom_range(0, 31768)));
                2:
                begin
                    neg = $urandom_range(0, 32768);
                    h   = 16'(-neg);
                end
                default: h = 16'($urandom_range(1001, 32767));
            endcase
        end
        else if (pick >= 75 && pick < 83)
        begin
            k = KIND_STATUS;
        end
        else if (pick >= 83 && pick < 88)
        begin
            k = KIND_RESET;
        end
        else if (pick >= 88)
        begin
            k  = 2'($urandom_range(0, 3));
            ok = 1'($urandom_range(0, 1));
            t  = 16'($urandom());
            h  = 16'($urandom());
        end

        sim_now = sim_now + $urandom_range(0, 4000);
        if ($urandom_range(0, 199) == 0)
            sim_now = 32'hFFFF_FFFF - $urandom_range(0, 20000);   // head for the wrap
        now = ($urandom_range(0, 15) == 0) ? $urandom() : sim_now;
        send_item(k, sl, ok, t, h, now);
    endtask

    initial
    begin : stimulus
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: nothing enabled, so a poll is ignored.
        send_item(KIND_POLL, 2'd1, 1'b1, 16'sd200, 16'sd400, 32'd5);
        send_item(KIND_STATUS, 2'd0, 1'b0, 16'sd0, 16'sd0, 32'd0);
        wait_idle();

        // Directed beats: short interval, tight cap, grace of one failure.
        set_config(32'd1000, 32'd2500, 32'd1, 32'hF, 32'hF);
        send_item(KIND_POLL, 2'd0, 1'b1, 16'sd250, 16'sd500, 32'd100);
        // plausible-window edges: coldest accepted temperature, humidity 100.0
        send_item(KIND_POLL, 2'd1, 1'b1, -16'sd999, 16'sd1000, 32'd200);
        // just outside: -100.0 degrees, 0 humidity, 100.1 humidity
        send_item(KIND_POLL, 2'd2, 1'b1, -16'sd1000, 16'sd500, 32'd300);
        send_item(KIND_POLL, 2'd2, 1'b1, 16'sd100, 16'sd0, 32'd310);
        send_item(KIND_POLL, 2'd2, 1'b1, 16'sd100, 16'sd1001, 32'd320);  // delay capped
        send_item(KIND_POLL, 2'd3, 1'b1, 16'sh7FFF, 16'sd1, 32'd400);
        // first failure stays within grace, the second invalidates
        send_item(KIND_POLL, 2'd3, 1'b1, 16'sh8000, 16'sh8000, 32'd410);
        send_item(KIND_POLL, 2'd3, 1'b1, 16'sh7FFF, 16'sh7FFF, 32'd420);
        send_item(KIND_POLL, 2'd0, 1'b0, 16'sd250, 16'sd500, 32'd430);   // no fetch
        send_item(KIND_STATUS, 2'd0, 1'b1, 16'sd0, 16'sd0, 32'hFFFF_FFFF);
        send_item(KIND_UNUSED, 2'd1, 1'b1, 16'sd50, 16'sd50, 32'd500);
        send_item(KIND_RESET, 2'd1, 1'b0, 16'sd0, 16'sd0, 32'd600);
        // outcome before the slot is due is applied anyway
        send_item(KIND_POLL, 2'd0, 1'b1, 16'sd10, 16'sd20, 32'd700);
        // next poll time wraps past 2^32
        send_item(KIND_POLL, 2'd2, 1'b1, 16'sd0, 16'sd1, 32'hFFFF_FF00);
        send_item(KIND_STATUS, 2'd2, 1'b0, 16'sd0, 16'sd0, 32'hFFFF_FFFF);
        send_item(KIND_STATUS, 2'd3, 1'b0, 16'sd0, 16'sd0, 32'd0);
        send_item(KIND_RESET, 2'd3, 1'b1, 16'sh5A5A, 16'shA5A5, 32'd800);
        send_item(KIND_POLL, 2'd1, 1'b1, -16'sd5, 16'sd3, 32'd900);
        send_item(KIND_STATUS, 2'd1, 1'b0, 16'sd0, 16'sd0, 32'd1000);

        // Random phases, each under its own register settings.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_idle();
            case (ph)
                0: set_config(32'd2000, 32'd7000, 32'd2, 32'hF, 32'hF);
                // zero interval: every delay is zero; slots 1 and 3 get disabled
                1: set_config(32'd0, 32'hFF_FFFF, 32'd0, 32'h5, 32'h3);
                // largest interval, cap of one, largest grace
                2: set_config(32'hFF_FFFF, 32'd1, 32'd255, 32'hF, 32'hF);
                // nobody joins the average
                3: set_config($urandom_range(1, 5000), $urandom_range(1, 20000),
                              $urandom_range(0, 5), $urandom_range(1, 15), 32'h0);
                4:
                begin
                    // all ones on the bus; upper bits must be dropped
                    write_reg(REG_ENABLE, 32'hFFFF_FFF0);
                    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FF03,
                               32'hFFFF_FFFA, 32'hFFFF_FFFF);
                end
                default: set_config($urandom_range(1, 5000), $urandom_range(1, 20000),
                                    $urandom_range(0, 4), $urandom_range(1, 15),
                                    $urandom_range(0, 15));
            endcase

            // final phase runs with no idling on either side
            if (ph == RANDOM_PHASES - 1)
            begin
                tx_gaps = 1'b0;
                rx_gaps = 1'b0;
            end

            if (ph == 2)
            begin
                // saturate the failure counter; grace 255 keeps the reading
                send_item(KIND_POLL, 2'd0, 1'b1, 16'sd123, 16'sd456, sim_now);
                for (int i = 0; i < SAT_RUN; i++)
                    send_item(KIND_POLL, 2'd0, 1'b0, 16'($urandom()), 16'($urandom()),
                              sim_now + i);
            end

            if (ph == 3)
                hold_request = 1'b1;   // receiver backs off while we keep offering

            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (ph == 5 && i == PHASE_ITEMS / 2)
                    wait_idle();
                send_random_item();
            end
        end

        wait_idle();
        repeat (12) @(posedge clk);

        $display("covered %0d input beats, %0d status beats checked, %0d register writes",
                 items_sent, results_seen, reg_writes);
        $display("phases: %0d random settings, failure saturation, long output hold-off",
                 RANDOM_PHASES);
        if (fail_count == 0 && outstanding == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// ===== sensor_poll_backoff_tracker_core.f =====
hw/rtl/spbt_pkg.sv
hw/rtl/spbt_ctrl.sv
hw/rtl/spbt_dp.sv
hw/rtl/sensor_poll_backoff_tracker_core.sv
bench/spbt_checker.sv
bench/tb.sv
